// ----- design/dmb_pkg.sv -----
// Shared types, constants and the blink period table for the disturbance monitor.
// No dependencies; used by dmb_eval and disturbance_monitor_blink_core.
package dmb_pkg;

    // Field and register widths
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 12;
    localparam int LIMIT_W         = 12;
    localparam int COUNT_W         = 8;
    localparam int FLAG_W          = 3;
    localparam int PERIOD_W        = 10;
    localparam int TIMER_W         = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRANK_THRESHOLD = 3'd5;

    // Reset values
    localparam logic [COUNT_W-1:0]  INTERVAL_RESET  = 8'd1;
    localparam logic [COUNT_W-1:0]  SETTLE_RESET    = 8'd10;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 12'd50;
    localparam logic [LIMIT_W-1:0]  THRESHOLD_RESET = 12'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 10'd500;

    // Flag bit positions
    localparam int FLAG_TEMP = 0;
    localparam int FLAG_VIN  = 1;
    localparam int FLAG_VOUT = 2;

    // Compare results handed from the evaluator to the core
    typedef struct packed {
        logic              mode;
        logic [FLAG_W-1:0] flags;
    } t_eval;

    // Map a flag code to its blink period
    function automatic logic [PERIOD_W-1:0] blink_period_of(input logic [FLAG_W-1:0] code);
        logic [PERIOD_W-1:0] p;
        unique case (code)
            3'd1:    p = 10'd1000;
            3'd2:    p = 10'd500;
            3'd3:    p = 10'd250;
            3'd4:    p = 10'd125;
            3'd5:    p = 10'd100;
            3'd6:    p = 10'd50;
            3'd7:    p = 10'd25;
            default: p = 10'd0;
        endcase
        return p;
    endfunction

endpackage

// ----- design/disturbance_monitor_blink_core.sv -----
// Disturbance monitor core: one request per tick, one result per request.
// A result is valid the cycle after its request is accepted.
// Throughput: one request per clock; the output register lets a new request in
// whenever the held result is taken in the same cycle or none is held.
// Reset (synchronous, active low) returns configuration and monitor state to their defaults.
// Depends on dmb_pkg and dmb_eval.
module disturbance_monitor_blink_core #(
    parameter int SAMPLE_BITS = dmb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Tick requests
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [SAMPLE_BITS-1:0]         i_temp_sample,
    input  logic [SAMPLE_BITS-1:0]         i_vin_sample,
    input  logic [SAMPLE_BITS-1:0]         i_vout_sample,
    input  logic [SAMPLE_BITS-1:0]         i_crank_sample,
    // Results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_boost_on,
    output logic                           o_led_on,
    output logic [dmb_pkg::FLAG_W-1:0]     o_disturb_flags,
    output logic [dmb_pkg::FLAG_W-1:0]     o_blink_code,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dmb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = dmb_pkg::COUNT_W;
    localparam int LW = dmb_pkg::LIMIT_W;
    localparam int FW = dmb_pkg::FLAG_W;
    localparam int PW = dmb_pkg::PERIOD_W;
    localparam int TW = dmb_pkg::TIMER_W;

    // Configuration registers
    logic [CW-1:0] r_sample_interval;
    logic [CW-1:0] r_settle_count;
    logic [LW-1:0] r_temp_limit;
    logic [LW-1:0] r_input_limit;
    logic [LW-1:0] r_output_limit;
    logic [LW-1:0] r_crank_threshold;

    // Monitor state
    logic [CW-1:0]          r_tick_counter,   n_tick_counter;
    logic [CW-1:0]          r_settle_counter, n_settle_counter;
    logic                   r_first_pending,  n_first_pending;
    logic                   r_settled_mode,   n_settled_mode;
    logic [SAMPLE_BITS-1:0] r_temp_base,      n_temp_base;
    logic [SAMPLE_BITS-1:0] r_vin_base,       n_vin_base;
    logic [SAMPLE_BITS-1:0] r_vout_base,      n_vout_base;
    logic [FW-1:0]          r_flag_bits,      n_flag_bits;
    logic [FW-1:0]          r_pattern_code,   n_pattern_code;
    logic [PW-1:0]          r_blink_period,   n_blink_period;
    logic [TW-1:0]          r_blink_timer,    n_blink_timer;
    logic                   r_led_level,      n_led_level;

    // Output register
    logic          r_out_valid;
    logic          r_boost_on;
    logic          r_led_on;
    logic [FW-1:0] r_disturb_flags;
    logic [FW-1:0] r_blink_code;

    logic           in_accept;
    dmb_pkg::t_eval eval;

    // Accept a request whenever the output register is empty or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_boost_on      = r_boost_on;
    assign o_led_on        = r_led_on;
    assign o_disturb_flags = r_disturb_flags;
    assign o_blink_code    = r_blink_code;

    dmb_eval #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_eval (
        .i_temp            (i_temp_sample),
        .i_vin             (i_vin_sample),
        .i_vout            (i_vout_sample),
        .i_crank           (i_crank_sample),
        .i_temp_base       (r_temp_base),
        .i_vin_base        (r_vin_base),
        .i_vout_base       (r_vout_base),
        .i_temp_limit      (r_temp_limit),
        .i_input_limit     (r_input_limit),
        .i_output_limit    (r_output_limit),
        .i_crank_threshold (r_crank_threshold),
        .o_eval            (eval)
    );

    // Next state for one tick
    always_comb begin
        n_tick_counter   = r_tick_counter;
        n_settle_counter = r_settle_counter;
        n_first_pending  = r_first_pending;
        n_settled_mode   = r_settled_mode;
        n_temp_base      = r_temp_base;
        n_vin_base       = r_vin_base;
        n_vout_base      = r_vout_base;
        n_flag_bits      = r_flag_bits;
        n_pattern_code   = r_pattern_code;
        n_blink_period   = r_blink_period;
        n_blink_timer    = r_blink_timer;
        n_led_level      = r_led_level;

        // Evaluate on interval match, otherwise count on
        if (r_tick_counter == r_sample_interval) begin
            n_tick_counter = '0;
            priority if (r_settled_mode == eval.mode) begin
                if (r_first_pending) begin
                    // Capture baselines once input voltage is present
                    if (i_vin_sample != '0) begin
                        n_first_pending = 1'b0;
                        n_temp_base     = i_temp_sample;
                        n_vin_base      = i_vin_sample;
                        n_vout_base     = i_vout_sample;
                    end
                end else begin
                    n_flag_bits    = eval.flags;
                    n_pattern_code = eval.flags;
                    if (eval.flags == '0) begin
                        n_led_level = 1'b0;
                    end else begin
                        n_blink_period = dmb_pkg::blink_period_of(eval.flags);
                    end
                end
            end else if (r_settle_counter != '0) begin
                n_settle_counter = r_settle_counter - CW'(1);
            end else begin
                // Settled: rebaseline under the new mode
                n_settle_counter = r_settle_count;
                n_temp_base      = i_temp_sample;
                n_vin_base       = i_vin_sample;
                n_vout_base      = i_vout_sample;
                n_settled_mode   = eval.mode;
            end
        end else begin
            n_tick_counter = r_tick_counter + CW'(1);
        end

        // Advance the blink timer while a pattern is active
        if (n_pattern_code != '0) begin
            if (r_blink_timer >= TW'(n_blink_period)) begin
                n_blink_timer = '0;
                n_led_level   = !n_led_level;
            end else begin
                n_blink_timer = r_blink_timer + TW'(1);
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_interval <= dmb_pkg::INTERVAL_RESET;
            r_settle_count    <= dmb_pkg::SETTLE_RESET;
            r_temp_limit      <= dmb_pkg::LIMIT_RESET;
            r_input_limit     <= dmb_pkg::LIMIT_RESET;
            r_output_limit    <= dmb_pkg::LIMIT_RESET;
            r_crank_threshold <= dmb_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dmb_pkg::CFG_SAMPLE_INTERVAL: r_sample_interval <= i_cfg_data[CW-1:0];
                dmb_pkg::CFG_SETTLE_COUNT:    r_settle_count    <= i_cfg_data[CW-1:0];
                dmb_pkg::CFG_TEMP_LIMIT:      r_temp_limit      <= i_cfg_data[LW-1:0];
                dmb_pkg::CFG_INPUT_LIMIT:     r_input_limit     <= i_cfg_data[LW-1:0];
                dmb_pkg::CFG_OUTPUT_LIMIT:    r_output_limit    <= i_cfg_data[LW-1:0];
                dmb_pkg::CFG_CRANK_THRESHOLD: r_crank_threshold <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Commit state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_counter   <= '0;
            r_settle_counter <= dmb_pkg::SETTLE_RESET;
            r_first_pending  <= 1'b1;
            r_settled_mode   <= 1'b0;
            r_temp_base      <= '0;
            r_vin_base       <= '0;
            r_vout_base      <= '0;
            r_flag_bits      <= '0;
            r_pattern_code   <= '0;
            r_blink_period   <= dmb_pkg::PERIOD_RESET;
            r_blink_timer    <= '0;
            r_led_level      <= 1'b0;
        end else if (in_accept) begin
            r_tick_counter   <= n_tick_counter;
            r_settle_counter <= n_settle_counter;
            r_first_pending  <= n_first_pending;
            r_settled_mode   <= n_settled_mode;
            r_temp_base      <= n_temp_base;
            r_vin_base       <= n_vin_base;
            r_vout_base      <= n_vout_base;
            r_flag_bits      <= n_flag_bits;
            r_pattern_code   <= n_pattern_code;
            r_blink_period   <= n_blink_period;
            r_blink_timer    <= n_blink_timer;
            r_led_level      <= n_led_level;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: load with this tick's result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_boost_on      <= eval.mode;
            r_led_on        <= n_led_level;
            r_disturb_flags <= n_flag_bits;
            r_blink_code    <= n_pattern_code;
        end
    end

`ifndef SYNTH
    // LED can only be lit while a blink pattern is active
    a_led_needs_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led_level |-> (r_pattern_code != '0))
        else $error("LED lit with no active blink pattern");

    // Pattern code always follows the last flag code
    a_pattern_tracks_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern_code == r_flag_bits)
        else $error("pattern code differs from flag bits");

    // No flags before the first baseline is captured
    a_no_flags_before_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_pending |-> (r_flag_bits == '0))
        else $error("flags raised before first baseline");

    // A held result is not overwritten without a request
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_blink_code)))
        else $error("stalled result changed");
`endif

endmodule

// ----- design/dmb_eval.sv -----
// Mode decision and per-channel deviation compares for one tick.
// Depends on dmb_pkg for widths and the t_eval result struct.
module dmb_eval #(
    parameter int SAMPLE_BITS = dmb_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]      i_temp,
    input  logic [SAMPLE_BITS-1:0]      i_vin,
    input  logic [SAMPLE_BITS-1:0]      i_vout,
    input  logic [SAMPLE_BITS-1:0]      i_crank,
    input  logic [SAMPLE_BITS-1:0]      i_temp_base,
    input  logic [SAMPLE_BITS-1:0]      i_vin_base,
    input  logic [SAMPLE_BITS-1:0]      i_vout_base,
    input  logic [dmb_pkg::LIMIT_W-1:0] i_temp_limit,
    input  logic [dmb_pkg::LIMIT_W-1:0] i_input_limit,
    input  logic [dmb_pkg::LIMIT_W-1:0] i_output_limit,
    input  logic [dmb_pkg::LIMIT_W-1:0] i_crank_threshold,
    output dmb_pkg::t_eval              o_eval
);

    localparam int CMP_W = (SAMPLE_BITS > dmb_pkg::LIMIT_W) ? SAMPLE_BITS : dmb_pkg::LIMIT_W;

    logic [SAMPLE_BITS-1:0] temp_dev;
    logic [SAMPLE_BITS-1:0] vin_dev;
    logic [SAMPLE_BITS-1:0] vout_dev;

    // Absolute deviation from baseline
    assign temp_dev = (i_temp >= i_temp_base) ? (i_temp - i_temp_base) : (i_temp_base - i_temp);
    assign vin_dev  = (i_vin  >= i_vin_base)  ? (i_vin  - i_vin_base)  : (i_vin_base  - i_vin);
    assign vout_dev = (i_vout >= i_vout_base) ? (i_vout - i_vout_base) : (i_vout_base - i_vout);

    // Boost when crank is above threshold; flag channels over their limit
    always_comb begin
        o_eval.mode = CMP_W'(i_crank) > CMP_W'(i_crank_threshold);
        o_eval.flags[dmb_pkg::FLAG_TEMP] = CMP_W'(temp_dev) > CMP_W'(i_temp_limit);
        o_eval.flags[dmb_pkg::FLAG_VIN]  = CMP_W'(vin_dev)  > CMP_W'(i_input_limit);
        o_eval.flags[dmb_pkg::FLAG_VOUT] = CMP_W'(vout_dev) > CMP_W'(i_output_limit);
    end

endmodule
